// File: rtl/core/msgd_pkg.sv
`timescale 1ns / 1ps

package msgd_pkg;

    // Size of the weight and update memories.
    localparam int NUM_WEIGHTS = 1024;
    localparam int IDX_W       = $clog2(NUM_WEIGHTS);

    // Command codes.
    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_GRADIENT = 2'd1;
    localparam logic [1:0] CMD_EPOCH    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MOMENTUM     = 2'd0;
    localparam logic [1:0] CFG_DECAY_FACTOR = 2'd1;
    localparam logic [1:0] CFG_INITIAL_RATE = 2'd2;

    // Reset values of the configuration and the rate state.
    localparam logic [15:0] MOMENTUM_RST     = 16'd58982;
    localparam logic [15:0] DECAY_FACTOR_RST = 16'd32768;
    localparam logic [31:0] INITIAL_RATE_RST = 32'd167772;
    localparam logic [31:0] LAST_ERROR_RST   = 32'hFFFF_FFFF;

    // One input transaction.
    typedef struct packed {
        logic [1:0]         command;
        logic [9:0]         weight_index;
        logic signed [31:0] operand_value;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [31:0] new_weight;
        logic [31:0]        current_rate;
        logic               rate_lowered;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GMUL_LO,
        ST_GMUL_HI,
        ST_GROUND,
        ST_GSAT,
        ST_GWRITE,
        ST_EMUL,
        ST_EROUND,
        ST_EDIV,
        ST_EADD,
        ST_OUT
    } state_t;

endpackage

// File: rtl/core/momentum_sgd_weight_update.sv
`timescale 1ns / 1ps

// Momentum SGD weight updater with a bold-driver learning rate. Weights and
// the update last applied to each weight live in two synchronous memories
// of msgd_pkg::NUM_WEIGHTS entries each. The block works on one transaction
// at a time under a small sequencer, and the result register lets the next
// transaction start while a result still waits on the m_ side. Steps per
// transaction: load, unused command or out-of-range index go straight to
// the output state; apply gradient takes a memory read, two partial
// products for gradient*rate with the momentum product alongside, rounding,
// saturation and write-back; epoch error multiplies the rate by its factor
// and rounds, and ends there when the error rose; otherwise the rate
// increment is rounded, divided by ten through a reciprocal multiplication
// and added with saturation. A result that still waits on the m_ side
// holds the block in its output state until it is taken.
// Configuration writes are always accepted and must only be issued while
// the block is idle. Applying a gradient to a weight that was never loaded
// returns an undefined weight.
module momentum_sgd_weight_update (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msgd_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output msgd_pkg::out_item_t m_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam logic [31:0]        RECIP_FIVE = 32'hCCCC_CCCD;
    localparam logic signed [64:0] T1_HALF    = 65'sd8388608;
    localparam logic signed [48:0] T2_HALF    = 49'sd32768;
    localparam logic [48:0]        DEC_HALF   = 49'd32768;
    localparam logic [48:0]        GROW_HALF  = 49'd327680;
    localparam logic [16:0]        ONE_Q16    = 17'h10000;

    // Clamp a wide signed value into the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -42'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return $signed(v[31:0]);
        end
    endfunction

    // Weight and previous-update memories.
    logic signed [31:0] weight_mem [msgd_pkg::NUM_WEIGHTS];
    logic signed [31:0] update_mem [msgd_pkg::NUM_WEIGHTS];

    msgd_pkg::state_t state_reg, state_next;

    // Configuration and rate state.
    logic [15:0] momentum_reg;
    logic [15:0] decay_reg;
    logic [31:0] rate_reg;
    logic [31:0] last_error_reg;

    // Working registers of the current transaction.
    logic [1:0]                    cmd_reg;
    logic [msgd_pkg::IDX_W-1:0]    idx_reg;
    logic signed [31:0]            opnd_reg;
    logic signed [31:0]            weight_rd_reg;
    logic signed [31:0]            update_rd_reg;
    logic signed [48:0]            prod_lo_reg;
    logic signed [48:0]            prod_hi_reg;
    logic signed [48:0]            prod_m_reg;
    logic signed [40:0]            t1_reg;
    logic signed [32:0]            t2_reg;
    logic signed [31:0]            upd_reg;
    logic [48:0]                   prod_e_reg;
    logic [32:0]                   quot_reg;
    logic signed [31:0]            res_weight_reg;
    logic                          res_lowered_reg;
    logic                          m_valid_reg;
    msgd_pkg::out_item_t           m_item_reg;

    // Control strobes.
    logic                          accept;
    logic                          in_range;
    logic [msgd_pkg::IDX_W-1:0]    in_addr;
    logic                          mem_re;
    logic                          mem_we;
    logic [msgd_pkg::IDX_W-1:0]    mem_waddr;
    logic signed [31:0]            weight_wdata;
    logic signed [31:0]            update_wdata;
    logic                          out_load;
    logic                          cfg_we;

    // Datapath values.
    logic signed [64:0]            t1_full;
    logic signed [48:0]            t2_full;
    logic signed [41:0]            upd_sum;
    logic signed [41:0]            nw_diff;
    logic signed [31:0]            nw_next;
    logic                          err_rose;
    logic [16:0]                   rate_factor;
    logic [48:0]                   prod_e_round;
    logic [63:0]                   recip_prod;
    logic [33:0]                   rate_sum;
    logic [31:0]                   rate_grown;

    assign in_range  = 32'(s_item.weight_index) < msgd_pkg::NUM_WEIGHTS;
    assign in_addr   = msgd_pkg::IDX_W'(32'(s_item.weight_index));
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msgd_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_item.command == msgd_pkg::CMD_GRADIENT && in_range) begin
                        state_next = msgd_pkg::ST_GMUL_LO;
                    end else if (s_item.command == msgd_pkg::CMD_EPOCH) begin
                        state_next = msgd_pkg::ST_EMUL;
                    end else begin
                        state_next = msgd_pkg::ST_OUT;
                    end
                end
            end
            msgd_pkg::ST_GMUL_LO: state_next = msgd_pkg::ST_GMUL_HI;
            msgd_pkg::ST_GMUL_HI: state_next = msgd_pkg::ST_GROUND;
            msgd_pkg::ST_GROUND:  state_next = msgd_pkg::ST_GSAT;
            msgd_pkg::ST_GSAT:    state_next = msgd_pkg::ST_GWRITE;
            msgd_pkg::ST_GWRITE:  state_next = msgd_pkg::ST_OUT;
            msgd_pkg::ST_EMUL:    state_next = msgd_pkg::ST_EROUND;
            msgd_pkg::ST_EROUND: begin
                state_next = res_lowered_reg ? msgd_pkg::ST_OUT : msgd_pkg::ST_EDIV;
            end
            msgd_pkg::ST_EDIV:    state_next = msgd_pkg::ST_EADD;
            msgd_pkg::ST_EADD:    state_next = msgd_pkg::ST_OUT;
            msgd_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = msgd_pkg::ST_IDLE;
                end
            end
            default:              state_next = msgd_pkg::ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        s_ready      = 1'b0;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        weight_wdata = nw_next;
        update_wdata = upd_reg;
        out_load     = 1'b0;
        case (state_reg)
            msgd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && in_range) begin
                    mem_re    = (s_item.command == msgd_pkg::CMD_GRADIENT);
                    mem_we    = (s_item.command == msgd_pkg::CMD_LOAD);
                    mem_waddr = in_addr;
                end
                weight_wdata = s_item.operand_value;
                update_wdata = '0;
            end
            msgd_pkg::ST_GWRITE: begin
                mem_we = 1'b1;
            end
            msgd_pkg::ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            weight_mem[mem_waddr] <= weight_wdata;
            update_mem[mem_waddr] <= update_wdata;
        end
        if (mem_re) begin
            weight_rd_reg <= weight_mem[in_addr];
            update_rd_reg <= update_mem[in_addr];
        end
    end

    // Gradient arithmetic: rounding of both products, sum and new weight.
    always_comb begin
        t1_full = (65'(prod_hi_reg) <<< 16) + 65'(prod_lo_reg) + T1_HALF;
        t2_full = prod_m_reg + T2_HALF;
        upd_sum = 42'(t1_reg) + 42'(t2_reg);
        nw_diff = 42'(weight_rd_reg) - 42'(upd_reg);
        nw_next = sat32(nw_diff);
    end

    // Epoch arithmetic: rate factor, rounding, divide by ten and growth.
    // The division halves the rounded value and multiplies it by the
    // reciprocal of five, which is exact for every 32-bit dividend.
    always_comb begin
        err_rose     = $unsigned(opnd_reg) > last_error_reg;
        rate_factor  = err_rose ? {1'b0, decay_reg} : ONE_Q16 - {1'b0, decay_reg};
        prod_e_round = prod_e_reg + (res_lowered_reg ? DEC_HALF : GROW_HALF);
        recip_prod   = {32'd0, quot_reg[32:1]} * {32'd0, RECIP_FIVE};
        rate_sum     = {2'b00, rate_reg} + {1'b0, quot_reg};
        rate_grown   = (rate_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : rate_sum[31:0];
    end

    // Working registers, stepped by the sequencer.
    always_ff @(posedge aclk) begin
        case (state_reg)
            msgd_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_reg         <= s_item.command;
                    idx_reg         <= in_addr;
                    opnd_reg        <= s_item.operand_value;
                    res_lowered_reg <= 1'b0;
                    if (s_item.command == msgd_pkg::CMD_LOAD && in_range) begin
                        res_weight_reg <= s_item.operand_value;
                    end else begin
                        res_weight_reg <= '0;
                    end
                end
            end
            msgd_pkg::ST_GMUL_LO: begin
                prod_lo_reg <= opnd_reg * $signed({1'b0, rate_reg[15:0]});
                prod_m_reg  <= update_rd_reg * $signed({1'b0, momentum_reg});
            end
            msgd_pkg::ST_GMUL_HI: begin
                prod_hi_reg <= opnd_reg * $signed({1'b0, rate_reg[31:16]});
            end
            msgd_pkg::ST_GROUND: begin
                t1_reg <= t1_full[64:24];
                t2_reg <= t2_full[48:16];
            end
            msgd_pkg::ST_GSAT: begin
                upd_reg <= sat32(upd_sum);
            end
            msgd_pkg::ST_GWRITE: begin
                res_weight_reg <= nw_next;
            end
            msgd_pkg::ST_EMUL: begin
                prod_e_reg      <= rate_reg * rate_factor;
                res_lowered_reg <= err_rose;
            end
            msgd_pkg::ST_EROUND: begin
                quot_reg <= prod_e_round[48:16];
            end
            msgd_pkg::ST_EDIV: begin
                // Quotient of the rounded increment by ten.
                quot_reg <= {3'b000, recip_prod[63:34]};
            end
            default: begin
                cmd_reg <= cmd_reg;
            end
        endcase
    end

    // Control state: sequencer, configuration, rate and last error.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= msgd_pkg::ST_IDLE;
            momentum_reg   <= msgd_pkg::MOMENTUM_RST;
            decay_reg      <= msgd_pkg::DECAY_FACTOR_RST;
            rate_reg       <= msgd_pkg::INITIAL_RATE_RST;
            last_error_reg <= msgd_pkg::LAST_ERROR_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    msgd_pkg::CFG_MOMENTUM:     momentum_reg <= cfg_data[15:0];
                    msgd_pkg::CFG_DECAY_FACTOR: decay_reg    <= cfg_data[15:0];
                    msgd_pkg::CFG_INITIAL_RATE: rate_reg     <= cfg_data;
                    default:                    momentum_reg <= momentum_reg;
                endcase
            end else if (state_reg == msgd_pkg::ST_EROUND && res_lowered_reg) begin
                rate_reg <= prod_e_round[47:16];
            end else if (state_reg == msgd_pkg::ST_EADD) begin
                rate_reg <= rate_grown;
            end
            if (state_reg == msgd_pkg::ST_EMUL) begin
                last_error_reg <= $unsigned(opnd_reg);
            end
        end
    end

    // Result register between the sequencer and the m_ side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg.new_weight   <= res_weight_reg;
            m_item_reg.current_rate <= rate_reg;
            m_item_reg.rate_lowered <= res_lowered_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Only one transaction is in work at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while one is in work");

    // A waiting result stays valid and unchanged until it is taken.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("waiting result dropped or changed");

    // A decayed rate only comes from an epoch error, which carries no weight.
    a_lowered_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && res_lowered_reg |-> res_weight_reg == '0 && cmd_reg == msgd_pkg::CMD_EPOCH)
        else $error("rate_lowered set on a weight result");

endmodule
